### rtl/clcd_pkg.sv
// Shared types and constants for the connection list decoder.
// Depends on nothing; every other file of the block imports it.
package clcd_pkg;

    // Command codes of an input request
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_WORD  = 2'd1;
    localparam logic [1:0] CMD_NEXT  = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_FETCH     = 2'd0;
    localparam logic [1:0] KIND_CONN      = 2'd1;
    localparam logic [1:0] KIND_DONE      = 2'd2;
    localparam logic [1:0] KIND_MISPLACED = 2'd3;

    // Walk phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_AWAIT = 2'd1;
    localparam logic [1:0] PH_RUN   = 2'd2;
    localparam logic [1:0] PH_FETCH = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_LIST_LENGTH = 2'd0;
    localparam logic [1:0] CFG_LONG_FORM   = 2'd1;
    localparam logic [1:0] CFG_GROUP_BASE  = 2'd2;
    localparam logic [1:0] CFG_GROUP_COUNT = 2'd3;

    // Node numbers at or above this limit are never valid
    localparam logic [15:0] C_MAX_NODES = 16'd128;

    localparam logic [15:0] C_COUNT_MAX = 16'hffff;

    typedef struct packed {
        logic [6:0] list_length;
        logic       long_form;
        logic [6:0] group_base;
        logic [7:0] group_count;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  phase;
        logic [6:0]  entry_index;
        logic [31:0] word_shift;
        logic [14:0] previous_node;
        logic [14:0] range_target;
        logic        in_range;
        logic [15:0] conn_count;
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  fetch_index;
        logic [15:0] slot;
        logic [14:0] node_id;
        logic        node_valid;
    } t_result;

endpackage

### rtl/clcd_cfg_regs.sv
// Configuration registers of the connection list decoder.
// Depends on clcd_pkg for the register indexes and the t_cfg struct.
module clcd_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_index,
    input  logic [7:0]     i_cfg_data,
    output clcd_pkg::t_cfg o_cfg
);
    import clcd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LIST_LENGTH: r_cfg.list_length <= i_cfg_data[6:0];
                CFG_LONG_FORM:   r_cfg.long_form   <= i_cfg_data[0];
                CFG_GROUP_BASE:  r_cfg.group_base  <= i_cfg_data[6:0];
                CFG_GROUP_COUNT: r_cfg.group_count <= i_cfg_data;
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/clcd_step.sv
// Single-step decode logic: next walk state and result for one request.
// Depends on clcd_pkg for codes and the state, config and result structs.
module clcd_step (
    input  clcd_pkg::t_cfg    i_cfg,
    input  clcd_pkg::t_state  i_state,
    input  logic [1:0]        i_command,
    input  logic [31:0]       i_response_word,
    output clcd_pkg::t_state  o_state,
    output clcd_pkg::t_result o_result
);
    import clcd_pkg::*;

    t_state      w;
    logic        adv;
    logic        do_emit;
    logic        do_consume;
    logic        do_range;
    logic [14:0] emit_node;
    logic [14:0] target;
    logic [14:0] entry_node;
    logic        entry_top;
    logic [15:0] prev_inc;
    logic [15:0] group_end;
    logic [6:0]  idx_inc;
    logic [1:0]  per_word_mask;

    always_comb begin
        // Apply the command to the current state
        w        = i_state;
        adv      = 1'b0;
        o_result = '0;
        if (i_command == CMD_START) begin
            w       = '0;
            w.phase = PH_FETCH;
            adv     = 1'b1;
        end else if (i_command == CMD_WORD && i_state.phase == PH_AWAIT) begin
            w.word_shift = i_response_word;
            w.phase      = PH_RUN;
            adv          = 1'b1;
        end else if (i_command == CMD_NEXT &&
                     (i_state.phase == PH_RUN || i_state.phase == PH_FETCH)) begin
            adv = 1'b1;
        end else begin
            o_result.kind = KIND_MISPLACED;
        end

        // Current entry
        if (i_cfg.long_form) begin
            entry_node = w.word_shift[14:0];
            entry_top  = w.word_shift[15];
        end else begin
            entry_node = {8'd0, w.word_shift[6:0]};
            entry_top  = w.word_shift[7];
        end

        o_state    = w;
        do_emit    = 1'b0;
        do_consume = 1'b0;
        do_range   = 1'b0;
        emit_node  = entry_node;
        target     = w.range_target;
        prev_inc   = {1'b0, w.previous_node} + 16'd1;

        if (adv) begin
            if (w.in_range) begin
                do_range = 1'b1;
            end else if (w.entry_index >= i_cfg.list_length) begin
                o_result.kind = KIND_DONE;
                o_result.slot = w.conn_count;
                o_state.phase = PH_IDLE;
            end else if (w.phase == PH_FETCH) begin
                o_result.kind        = KIND_FETCH;
                o_result.fetch_index = w.entry_index;
                o_state.phase        = PH_AWAIT;
            end else if (entry_top && w.entry_index != 7'd0) begin
                target               = entry_node;
                o_state.range_target = entry_node;
                do_range             = 1'b1;
            end else begin
                do_emit    = 1'b1;
                do_consume = 1'b1;
            end
        end

        // Range: step one node past the previous one, or finish on the target
        if (do_range) begin
            do_emit = 1'b1;
            if (prev_inc < {1'b0, target}) begin
                emit_node        = prev_inc[14:0];
                o_state.in_range = 1'b1;
            end else begin
                emit_node        = target;
                o_state.in_range = 1'b0;
                do_consume       = 1'b1;
            end
        end

        group_end = {8'd0, i_cfg.group_base} + {8'd0, i_cfg.group_count};
        if (do_emit) begin
            o_result.kind       = KIND_CONN;
            o_result.slot       = w.conn_count;
            o_result.node_id    = emit_node;
            o_result.node_valid = ({1'b0, emit_node} < C_MAX_NODES) &&
                                  (emit_node >= {8'd0, i_cfg.group_base}) &&
                                  ({1'b0, emit_node} < group_end);
            if (w.conn_count != C_COUNT_MAX) begin
                o_state.conn_count = w.conn_count + 16'd1;
            end
            o_state.previous_node = emit_node;
        end

        idx_inc       = w.entry_index + 7'd1;
        per_word_mask = i_cfg.long_form ? 2'b01 : 2'b11;
        if (do_consume) begin
            o_state.entry_index = idx_inc;
            o_state.word_shift  = i_cfg.long_form ? (w.word_shift >> 16)
                                                  : (w.word_shift >> 8);
            if ((idx_inc[1:0] & per_word_mask) == 2'b00) begin
                o_state.phase = PH_FETCH;
            end
        end
    end

endmodule

### rtl/connection_list_decoder_unit.sv
// Top level of the connection list decoder: input register, walk state,
// result register. Depends on clcd_pkg, clcd_cfg_regs and clcd_step.
//
//  Channel   Direction  Handshake                  Payload
//  -------   ---------  -------------------------  ------------------------------
//  in        request    i_in_valid / o_in_ready    i_command, i_response_word
//  out       result     o_out_valid / i_out_ready  o_kind, o_fetch_index, o_slot,
//                                                  o_node_id, o_node_valid
//  cfg       write      i_cfg_we                   i_cfg_index, i_cfg_data
//
// Flow: each request gives exactly one result, which passes the input register
// and then the result register. One request per cycle is sustained while the
// result channel is not stalled; the limit is the loop through the walk state
// register and clcd_step.
// Reset: synchronous, active low; clears the walk state, both valid flags and
// the configuration registers.
// Stalls: a held result blocks only the input register; the input register
// still takes a request whenever it is empty or is being processed.
module connection_list_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_response_word,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [6:0]  o_fetch_index,
    output logic [15:0] o_slot,
    output logic [14:0] o_node_id,
    output logic        o_node_valid
);
    import clcd_pkg::*;

    t_cfg        cfg;
    t_state      r_st;
    t_state      n_st;
    t_result     n_res;
    t_result     r_res;
    logic        r_in_valid;
    logic [1:0]  r_cmd;
    logic [31:0] r_word;
    logic        r_out_valid;
    logic        fire;

    clcd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    clcd_step u_step (
        .i_cfg           (cfg),
        .i_state         (r_st),
        .i_command       (r_cmd),
        .i_response_word (r_word),
        .o_state         (n_st),
        .o_result        (n_res)
    );

    // Process the held request when the result register is free or draining
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    // Input register: hold the request until it is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd  <= i_command;
            r_word <= i_response_word;
        end
    end

    // Walk state: advance once per processed request; all-zero is the idle phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (fire) begin
            r_st <= n_st;
        end
    end

    // Result register: load on process, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_res.kind;
    assign o_fetch_index = r_res.fetch_index;
    assign o_slot        = r_res.slot;
    assign o_node_id     = r_res.node_id;
    assign o_node_valid  = r_res.node_valid;

    // A range is only ever open while words are being walked
    a_range_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.in_range |-> r_st.phase == PH_RUN)
        else $error("range open outside run phase");

    // Only a start request may lower the connection count
    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_cmd != CMD_START |=> r_st.conn_count >= $past(r_st.conn_count))
        else $error("connection count went backward");

    // A next request while idle is always rejected
    a_idle_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_st.phase == PH_IDLE && r_cmd == CMD_NEXT
        |=> r_res.kind == KIND_MISPLACED)
        else $error("next request accepted while idle");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for connection_list_decoder_unit: walks connection lists under random
// idling on both channels and checks every result against an in-bench decoder.
// Depends on clcd_pkg and the decoder RTL only.
module tb_top;
    import clcd_pkg::*;

    // Command 3 has no meaning; the block must answer it as out of place
    localparam logic [1:0] CMD_ILLEGAL = 2'd3;

    // Cycles without any handshake before the run is declared hung
    localparam int STALL_LIMIT   = 1000;
    // Cycles to let pass once the result queue is empty (two-stage pipe plus margin)
    localparam int SETTLE_CYCLES = 6;

    // Receiver stall patterns
    localparam int RX_FREE     = 0;
    localparam int RX_COIN     = 1;
    localparam int RX_PERIODIC = 2;
    localparam int RX_MOSTLY   = 3;

    // ------------------------------------------------------------------
    // DUT ports; every input starts from a known value
    // ------------------------------------------------------------------
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic [1:0]  i_cfg_index     = CFG_LIST_LENGTH;
    logic [7:0]  i_cfg_data      = 8'd0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_command       = CMD_START;
    logic [31:0] i_response_word = 32'd0;
    logic        o_out_valid;
    logic        i_out_ready     = 1'b0;
    logic [1:0]  o_kind;
    logic [6:0]  o_fetch_index;
    logic [15:0] o_slot;
    logic [14:0] o_node_id;
    logic        o_node_valid;

    connection_list_decoder_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_response_word (i_response_word),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_kind          (o_kind),
        .o_fetch_index   (o_fetch_index),
        .o_slot          (o_slot),
        .o_node_id       (o_node_id),
        .o_node_valid    (o_node_valid)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder copy: configuration and walk state, both as after reset
    // ------------------------------------------------------------------
    logic [6:0]  c_len   = '0;
    logic        c_long  = 1'b0;
    logic [6:0]  c_base  = '0;
    logic [7:0]  c_count = '0;

    logic [1:0]  w_phase    = PH_IDLE;
    logic [6:0]  w_entry    = '0;
    logic [31:0] w_shift    = '0;
    logic [14:0] w_prev     = '0;
    logic [14:0] w_target   = '0;
    logic        w_in_range = 1'b0;
    logic [15:0] w_count    = '0;

    // Results the block owes, oldest first
    t_result     walk_results[$];
    // Words to hand out on fetch requests before falling back to random ones
    logic [31:0] word_feed[$];

    int n_fail     = 0;
    int walk_items = 0;
    int burst_left = 0;

    // Emit one connection: valid only inside the group and below the node limit.
    // The slot counter sticks at its maximum.
    function automatic t_result conn_result(input logic [14:0] node);
        t_result r;
        r            = '0;
        r.kind       = KIND_CONN;
        r.slot       = w_count;
        r.node_id    = node;
        r.node_valid = ({1'b0, node} < C_MAX_NODES) &&
                       (node >= {8'b0, c_base}) &&
                       ({1'b0, node} < {9'b0, c_base} + {8'b0, c_count});
        if (w_count != C_COUNT_MAX)
            w_count = w_count + 16'd1;
        w_prev = node;
        return r;
    endfunction

    // Drop the current entry; ask for a new word once the word is used up
    function automatic void consume_entry();
        w_entry = w_entry + 7'd1;
        w_shift = c_long ? (w_shift >> 16) : (w_shift >> 8);
        if ((w_entry & (c_long ? 7'd1 : 7'd3)) == 7'd0)
            w_phase = PH_FETCH;
    endfunction

    // Advance the walk by one result
    function automatic t_result walk_step();
        t_result     r;
        logic [15:0] entry;
        logic [15:0] node;
        r = '0;
        if (!w_in_range) begin
            if (w_entry >= c_len) begin
                r.kind  = KIND_DONE;
                r.slot  = w_count;
                w_phase = PH_IDLE;
                return r;
            end
            if (w_phase == PH_FETCH) begin
                r.kind        = KIND_FETCH;
                r.fetch_index = w_entry;
                w_phase       = PH_AWAIT;
                return r;
            end
            if (c_long) begin
                entry = w_shift[15:0];
                node  = {1'b0, w_shift[14:0]};
            end else begin
                entry = {8'b0, w_shift[7:0]};
                node  = {9'b0, w_shift[6:0]};
            end
            // The first entry is never a range, whatever its top bit says
            if (w_entry == 7'd0 || entry == node) begin
                r = conn_result(node[14:0]);
                consume_entry();
                return r;
            end
            w_target   = node[14:0];
            w_in_range = 1'b1;
        end
        // Range: step up from the previous node; a backward range gives its own node only
        if ({1'b0, w_prev} + 16'd1 < {1'b0, w_target}) begin
            r = conn_result(w_prev + 15'd1);
        end else begin
            r          = conn_result(w_target);
            w_in_range = 1'b0;
            consume_entry();
        end
        return r;
    endfunction

    // Apply one accepted request to the decoder copy and return its result
    function automatic t_result walk_request(input logic [1:0] cmd, input logic [31:0] word);
        t_result r;
        r = '0;
        if (cmd == CMD_START) begin
            w_phase    = PH_FETCH;
            w_entry    = '0;
            w_shift    = '0;
            w_prev     = '0;
            w_target   = '0;
            w_in_range = 1'b0;
            w_count    = '0;
            r          = walk_step();
        end else if (cmd == CMD_WORD && w_phase == PH_AWAIT) begin
            w_shift = word;
            w_phase = PH_RUN;
            r       = walk_step();
        end else if (cmd == CMD_NEXT && (w_phase == PH_RUN || w_phase == PH_FETCH)) begin
            r = walk_step();
        end else begin
            r.kind = KIND_MISPLACED;
        end
        return r;
    endfunction

    // Build a response word that mostly makes sense next to the current walk:
    // nodes around the group, short forward ranges, some backward ranges and noise
    function automatic logic [31:0] shaped_word();
        logic [31:0] w;
        logic [31:0] ent;
        int          p;
        int          node;
        int          width;
        int          max_node;
        bit          rng;
        w        = '0;
        p        = int'(w_prev);
        width    = c_long ? 16 : 8;
        max_node = c_long ? 32'h7fff : 32'h7f;
        for (int k = 0; k < 32 / width; k++) begin
            rng = 1'b0;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: node = $urandom_range(0, 140);
                4: begin
                    node = $urandom_range(0, max_node);
                    // a wide range in long form would step through tens of thousands of nodes
                    rng  = c_long ? 1'b0 : 1'($urandom_range(0, 1));
                end
                5, 6, 7: begin
                    node = p + $urandom_range(1, 6);
                    rng  = 1'b1;
                end
                8: begin
                    node = $urandom_range(0, p);
                    rng  = 1'b1;
                end
                default: node = p + 1;
            endcase
            if (node > max_node)
                node = max_node;
            ent = 32'(node);
            if (rng)
                ent[width - 1] = 1'b1;
            w = w | (ent << (k * width));
            p = node;
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Send one request: hold valid and payload until accepted, then update the
    // decoder copy. Insert a gap only at the end of a burst; otherwise leave valid
    // high for the next request, which the caller issues in this same step.
    task automatic send_req(input logic [1:0] cmd, input logic [31:0] word);
        int gap;
        gap             = 0;
        i_in_valid      <= 1'b1;
        i_command       <= cmd;
        i_response_word <= word;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        walk_results.push_back(walk_request(cmd, word));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            if ($urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(40, 120);
            end else begin
                burst_left = $urandom_range(0, 12);
                gap        = $urandom_range(1, 7);
            end
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stop sending and wait until the block owes nothing, then let the pipe settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (walk_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers back to back, only once the block is quiet
    task automatic set_config(input logic [6:0] len, input logic lf,
                              input logic [6:0] base, input logic [7:0] cnt);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_LIST_LENGTH;
        i_cfg_data  <= {1'b0, len};
        @(posedge i_clk);
        i_cfg_index <= CFG_LONG_FORM;
        i_cfg_data  <= {7'b0, lf};
        @(posedge i_clk);
        i_cfg_index <= CFG_GROUP_BASE;
        i_cfg_data  <= {1'b0, base};
        @(posedge i_clk);
        i_cfg_index <= CFG_GROUP_COUNT;
        i_cfg_data  <= cnt;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        c_len   = len;
        c_long  = lf;
        c_base  = base;
        c_count = cnt;
    endtask

    // Random settings, extremes favored
    task automatic random_config();
        logic [6:0] len;
        logic [6:0] base;
        logic [7:0] cnt;
        case ($urandom_range(0, 7))
            0:       len = 7'd0;
            1:       len = 7'd127;
            default: len = 7'($urandom_range(1, 24));
        endcase
        case ($urandom_range(0, 5))
            0:       base = 7'd0;
            1:       base = 7'd127;
            default: base = 7'($urandom_range(0, 127));
        endcase
        case ($urandom_range(0, 5))
            0:       cnt = 8'd0;
            1:       cnt = 8'd128;
            default: cnt = 8'($urandom_range(0, 128));
        endcase
        set_config(len, 1'($urandom_range(0, 1)), base, cnt);
    endtask

    // Follow the walk: hand out a word when one is asked for, otherwise ask for
    // the next connection, until the list is done or max_items requests went out.
    // With noisy set, mix in out-of-place commands, restarts and sender pauses.
    task automatic drive_walk(input bit do_start, input int max_items, input bit noisy);
        int          n;
        logic [31:0] w;
        n = 0;
        if (do_start) begin
            send_req(CMD_START, $urandom());
            n++;
        end
        while (w_phase != PH_IDLE && n < max_items) begin
            if (noisy && $urandom_range(0, 11) == 0) begin
                case ($urandom_range(0, 3))
                    0:       send_req(CMD_ILLEGAL, $urandom());
                    1:       send_req(w_phase == PH_AWAIT ? CMD_NEXT : CMD_WORD, $urandom());
                    2:       send_req(CMD_START, $urandom());
                    default: drain_results();
                endcase
            end else begin
                if (w_phase == PH_AWAIT) begin
                    w = (word_feed.size() != 0) ? word_feed.pop_front() : shaped_word();
                    send_req(CMD_WORD, w);
                end else begin
                    send_req(CMD_NEXT, $urandom());
                end
                walk_items++;
            end
            n++;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Commands out of place in the idle, await and run phases, and an empty list
    task automatic test_out_of_place();
        // still at reset settings: list length 0, block idle
        send_req(CMD_WORD, 32'hffff_ffff);
        send_req(CMD_NEXT, 32'h0);
        send_req(CMD_ILLEGAL, 32'h0);
        send_req(CMD_START, 32'h0);      // empty list: done with total 0
        send_req(CMD_NEXT, 32'h0);       // idle again
        set_config(7'd4, 1'b0, 7'd0, 8'd128);
        send_req(CMD_START, 32'h0);      // fetch for entry 0
        send_req(CMD_NEXT, 32'h0);       // a word is awaited
        send_req(CMD_ILLEGAL, 32'h0);
        send_req(CMD_WORD, 32'h0302_0100);
        send_req(CMD_WORD, 32'h0);       // no word awaited while running
        send_req(CMD_ILLEGAL, 32'h0);
        drive_walk(1'b0, 20, 1'b0);
    endtask

    // Short entries: top bit on the first entry, forward and backward ranges
    task automatic test_short_walk();
        set_config(7'd7, 1'b0, 7'd2, 8'd5);
        word_feed.push_back(32'h7f_82_84_81);
        word_feed.push_back(32'hff_80_83_00);
        drive_walk(1'b1, 100, 1'b0);
    endtask

    // Long entries near the top of the node space; group past the node limit
    task automatic test_long_walk();
        set_config(7'd3, 1'b1, 7'd120, 8'd128);
        word_feed.push_back(32'hffff_fffe);
        word_feed.push_back(32'h1234_0079);
        drive_walk(1'b1, 100, 1'b0);
    endtask

    // Settings changed in the middle of a walk, and a restart mid-walk
    task automatic test_midwalk_change();
        set_config(7'd10, 1'b0, 7'd0, 8'd128);
        drive_walk(1'b1, 4, 1'b0);
        set_config(7'd3, 1'b1, 7'd127, 8'd1);
        drive_walk(1'b0, 100, 1'b0);
        set_config(7'd5, 1'b1, 7'd0, 8'd0);
        drive_walk(1'b1, 3, 1'b0);
        drive_walk(1'b1, 100, 1'b0);
    endtask

    // Random walks under random settings, some changed mid-walk
    task automatic test_random();
        int target;
        target = walk_items + 800;
        while (walk_items < target) begin
            random_config();
            if ($urandom_range(0, 5) == 0) begin
                drive_walk(1'b1, $urandom_range(2, 12), 1'b1);
                random_config();
                drive_walk(1'b0, 400, 1'b1);
            end else begin
                drive_walk(1'b1, 400, 1'b1);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Receiver: switch to a random stall pattern whenever the current one runs out
    int rx_mode = RX_FREE;
    int rx_left = 0;
    int rx_div  = 2;

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(RX_FREE, RX_MOSTLY);
            rx_left = $urandom_range(8, 160);
            rx_div  = $urandom_range(2, 6);
        end
        rx_left--;
        case (rx_mode)
            RX_FREE:     i_out_ready <= 1'b1;
            RX_COIN:     i_out_ready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: i_out_ready <= (rx_left % rx_div) == 0;
            default:     i_out_ready <= $urandom_range(0, 4) != 0;
        endcase
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            n_fail++;
        end
    endtask

    // Compare each accepted result with the oldest one owed
    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (walk_results.size() == 0) begin
                $error("result with none owed: kind %0d slot %0d", o_kind, o_slot);
                n_fail++;
            end else begin
                r = walk_results.pop_front();
                check_field("kind", 32'(r.kind), 32'(o_kind));
                check_field("fetch_index", 32'(r.fetch_index), 32'(o_fetch_index));
                check_field("slot", 32'(r.slot), 32'(o_slot));
                check_field("node_id", 32'(r.node_id), 32'(o_node_id));
                check_field("node_valid", 32'(r.node_valid), 32'(o_node_valid));
            end
        end
    end

    // Hang detector: end the run after too many cycles without any handshake
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        // hold reset low from time zero, then release it at a clock edge
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_out_of_place();
        test_short_walk();
        test_long_walk();
        test_midwalk_change();
        test_random();

        drain_results();
        if (n_fail == 0 && walk_results.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

### filelist.f
rtl/clcd_pkg.sv
rtl/clcd_cfg_regs.sv
rtl/clcd_step.sv
rtl/connection_list_decoder_unit.sv
verif/tb_top.sv
